/* hdl/ssc_pkg.sv */
// Shared types, constants and the case-fold function of the substring search block.
package ssc_pkg;

    localparam int NEEDLE_MAX   = 16;
    localparam int HAYSTACK_MAX = 65536;
    localparam int LEN_W        = $clog2(NEEDLE_MAX + 1);
    localparam int IDX_W        = $clog2(NEEDLE_MAX);
    localparam int CNT_W        = $clog2(HAYSTACK_MAX + 1);
    localparam int START_W      = 16;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 64;

    localparam logic [START_W-1:0] START_MAX  = '1;
    localparam logic [7:0]         UPPER_A    = 8'h41;
    localparam logic [7:0]         UPPER_Z    = 8'h5A;
    localparam logic [7:0]         CASE_DELTA = 8'h20;

    typedef enum logic [1:0] {
        REG_NEEDLE_LOW    = 2'd0,
        REG_NEEDLE_HIGH   = 2'd1,
        REG_NEEDLE_LENGTH = 2'd2,
        REG_MATCH_CASE    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [NEEDLE_MAX-1:0][7:0] needle;
        logic [LEN_W-1:0]           needle_length;
        logic                       match_case;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic [START_W-1:0] match_start;
    } res_t;

    // Maps ASCII uppercase letters to lowercase unless the compare is exact.
    function automatic logic [7:0] fold(input logic [7:0] b, input logic exact);
        if (!exact && b >= UPPER_A && b <= UPPER_Z) begin
            return b + CASE_DELTA;
        end
        return b;
    endfunction

endpackage

/* hdl/ssc_cfg.sv */
// Configuration registers and APB-style access decode of the substring search block.
module ssc_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssc_pkg::DATA_W-1:0]  pwdata,
    output logic [ssc_pkg::DATA_W-1:0]  prdata,
    output ssc_pkg::cfg_t               cfg
);

    logic [63:0]                  needle_low_reg;
    logic [63:0]                  needle_high_reg;
    logic [ssc_pkg::LEN_W-1:0]    needle_length_reg;
    logic                         match_case_reg;
    ssc_pkg::reg_idx_t            reg_idx;
    logic                         wr_en;

    assign reg_idx = ssc_pkg::reg_idx_t'(paddr[ssc_pkg::ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_low_reg    <= '0;
            needle_high_reg   <= '0;
            needle_length_reg <= '0;
            match_case_reg    <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                ssc_pkg::REG_NEEDLE_LOW:    needle_low_reg    <= pwdata[63:0];
                ssc_pkg::REG_NEEDLE_HIGH:   needle_high_reg   <= pwdata[63:0];
                ssc_pkg::REG_NEEDLE_LENGTH: needle_length_reg <= pwdata[ssc_pkg::LEN_W-1:0];
                ssc_pkg::REG_MATCH_CASE:    match_case_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            ssc_pkg::REG_NEEDLE_LOW:    prdata = needle_low_reg;
            ssc_pkg::REG_NEEDLE_HIGH:   prdata = needle_high_reg;
            ssc_pkg::REG_NEEDLE_LENGTH: prdata = ssc_pkg::DATA_W'(needle_length_reg);
            ssc_pkg::REG_MATCH_CASE:    prdata = ssc_pkg::DATA_W'(match_case_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.needle        = {needle_high_reg, needle_low_reg};
    assign cfg.needle_length = needle_length_reg;
    assign cfg.match_case    = match_case_reg;

endmodule

/* hdl/ssc_core.sv */
// Byte window, position counter and parallel needle compare of the substring search block.
module ssc_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    text_byte,
    input  logic          final_byte,
    input  ssc_pkg::cfg_t cfg,
    output ssc_pkg::res_t res
);

    localparam int NM = ssc_pkg::NEEDLE_MAX;

    logic [NM-1:0][7:0]           win_reg;
    logic [NM-1:0][7:0]           win_next;
    logic [ssc_pkg::CNT_W-1:0]    cnt_reg;
    logic [ssc_pkg::CNT_W-1:0]    cnt_next;
    logic [ssc_pkg::CNT_W-1:0]    cnt_inc;
    logic [ssc_pkg::CNT_W-1:0]    start_full;
    logic                         reported_reg;
    logic                         reported_next;
    logic [ssc_pkg::LEN_W-1:0]    sel_pos [NM];
    logic [NM-1:0]                mismatch;
    logic                         active;
    logic                         len_zero;
    logic                         len_ok;
    logic                         hit;

    // Newest byte sits at index 0; the window shifts only while searching.
    assign win_next = {win_reg[NM-2:0], text_byte};
    assign cnt_inc  = cnt_reg + 1'b1;
    assign active   = !reported_reg && (cnt_reg < ssc_pkg::CNT_W'(ssc_pkg::HAYSTACK_MAX));
    assign len_zero = (cfg.needle_length == '0);
    assign len_ok   = (cfg.needle_length <= ssc_pkg::LEN_W'(NM));

    always_comb begin
        for (int k = 0; k < NM; k++) begin
            sel_pos[k]  = cfg.needle_length - ssc_pkg::LEN_W'(k) - 1'b1;
            mismatch[k] = (ssc_pkg::LEN_W'(k) < cfg.needle_length) &&
                          (ssc_pkg::fold(cfg.needle[k], cfg.match_case) !=
                           ssc_pkg::fold(win_next[sel_pos[k][ssc_pkg::IDX_W-1:0]],
                                         cfg.match_case));
        end
    end

    assign hit = active && (len_zero ||
                 (len_ok && cnt_inc >= ssc_pkg::CNT_W'(cfg.needle_length) && !(|mismatch)));
    assign start_full = len_zero ? '0 : cnt_inc - ssc_pkg::CNT_W'(cfg.needle_length);

    always_comb begin
        res.valid       = step && (hit || (final_byte && !reported_reg));
        res.found       = hit;
        res.match_start = '0;
        if (hit) begin
            if (start_full > ssc_pkg::CNT_W'(ssc_pkg::START_MAX)) begin
                res.match_start = ssc_pkg::START_MAX;
            end else begin
                res.match_start = start_full[ssc_pkg::START_W-1:0];
            end
        end
    end

    always_comb begin
        cnt_next      = cnt_reg;
        reported_next = reported_reg;
        if (step) begin
            if (active) begin
                cnt_next = cnt_inc;
            end
            if (hit) begin
                reported_next = 1'b1;
            end
            if (final_byte) begin
                cnt_next      = '0;
                reported_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            reported_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            reported_reg <= reported_next;
        end
    end

    // Window entries are read only below the byte count, so they need no clearing.
    always_ff @(posedge aclk) begin
        if (step && active) begin
            win_reg <= win_next;
        end
    end

    a_silent_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        step && reported_reg && !final_byte |-> !res.valid)
        else $error("result given after a match was already reported");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= ssc_pkg::CNT_W'(ssc_pkg::HAYSTACK_MAX))
        else $error("byte count passed its saturation value");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && final_byte |=> cnt_reg == '0 && !reported_reg)
        else $error("last byte did not clear the stream state");

    a_one_found: assert property (@(posedge aclk) disable iff (!aresetn)
        reported_reg && !$past(final_byte && step) |-> !hit)
        else $error("second match raised within one haystack");

endmodule

/* hdl/substring_search_case_fold.sv */
// Top level of the substring search block: input word register, result register, config port.
//
//   Channel  | Direction | Handshake              | Word
//   ---------+-----------+------------------------+-------------------------------------
//   s_       | in        | s_valid / s_ready      | s_text_byte, s_final_byte
//   m_       | out       | m_valid / m_ready      | m_found, m_match_start
//   APB      | in        | psel/penable/pready    | paddr, pwdata, prdata (64-bit)
//
// Each word is compared with the needle in the input register; a haystack's first
// match, or its last byte if none matched, leaves a result in the output register,
// and bytes stream at one per cycle unless stalled; the window compare is the
// whole per-byte path. A word is held in the input register only while a result
// waits unaccepted in the output register. Reset (aresetn low at a clock edge)
// empties both registers and restores the register defaults: empty needle,
// exact compare. Configuration must be written while no haystack is in flight.
module substring_search_case_fold (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_text_byte,
    input  logic                        s_final_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [15:0]                 m_match_start,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssc_pkg::DATA_W-1:0]  pwdata,
    output logic [ssc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    ssc_pkg::cfg_t cfg;
    ssc_pkg::res_t res;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_final_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_found_reg;
    logic [15:0] out_start_reg;
    logic       out_free;
    logic       step;
    logic       s_take;

    assign pready = 1'b1;

    ssc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The output register can take a new result when empty or being drained now.
    assign out_free = !out_valid_reg || m_ready;
    // The held word is processed as soon as its result has somewhere to go.
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step;
    assign s_take   = s_valid && s_ready;

    ssc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .text_byte  (in_byte_reg),
        .final_byte (in_final_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg  <= s_text_byte;
            in_final_reg <= s_final_byte;
        end
        if (out_free && res.valid) begin
            out_found_reg <= res.found;
            out_start_reg <= res.match_start;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_found       = out_found_reg;
    assign m_match_start = out_start_reg;

endmodule
